### hdl/gnss_binary_frame_parser_top_macros.svh
// Assertion macros used by the parser's top-level RTL file.
// Outside of synthesis each macro expands to a labeled concurrent assertion
// on clk_i; for synthesis the macros expand to nothing.
`ifndef GNSS_BINARY_FRAME_PARSER_TOP_MACROS_SVH
`define GNSS_BINARY_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTH

// Property checked only while reset is released.
`define GBFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property checked at every edge, during reset too.
`define GBFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define GBFP_ASSERT(lbl, prop, msg)
`define GBFP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/gbfp_pkg.sv
package gbfp_pkg;

  // Payload store depth and its address width.
  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned STORE_AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Parser phases; codes above PH_CKB are unused and fall back to the hunt.
  typedef enum logic [3:0] {
    PH_HUNT1 = 4'd0,
    PH_HUNT2 = 4'd1,
    PH_CLASS = 4'd2,
    PH_IDENT = 4'd3,
    PH_LENLO = 4'd4,
    PH_LENHI = 4'd5,
    PH_BODY  = 4'd6,
    PH_CKA   = 4'd7,
    PH_CKB   = 4'd8
  } phase_e;

  // Frame end status reported with each byte.
  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // One result item.
  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  frame_class;
    logic [7:0]  frame_ident;
    logic [15:0] frame_length;
    logic        payload_truncated;
    logic        payload_valid;
    logic [8:0]  payload_index;
    logic [7:0]  payload_data;
  } result_t;

  // Write request into the payload store.
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

### hdl/gbfp_if.sv
// Input byte channel.
interface gbfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel, one result per received byte.
interface gbfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  frame_class;
  logic [7:0]  frame_ident;
  logic [15:0] frame_length;
  logic        payload_truncated;
  logic        payload_valid;
  logic [8:0]  payload_index;
  logic [7:0]  payload_data;

  modport source (
    output valid, input ready,
    output frame_status, output frame_class, output frame_ident,
    output frame_length, output payload_truncated, output payload_valid,
    output payload_index, output payload_data
  );
  modport sink (
    input valid, output ready,
    input frame_status, input frame_class, input frame_ident,
    input frame_length, input payload_truncated, input payload_valid,
    input payload_index, input payload_data
  );
endinterface

### hdl/gnss_binary_frame_parser_top.sv
// Byte-serial parser for binary GNSS frames with an 8-bit Fletcher checksum.
// Channel rx_i carries one received byte per transaction; channel res_o
// returns exactly one result per byte, in order: the frame end status, the
// class, id and declared length of the current frame, the truncated flag, and
// for payload bytes that fit the store their index and value.
// The result is registered: it is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while res_o.ready is high. Each byte is a
// single pass through the phase logic, and the payload store takes one write
// per cycle on its only port. The result register drains and refills in the
// same cycle, so rx_i.ready stays high while res_o.ready is high.
// When the receiver stalls, the result holds in the output register and
// rx_i.ready drops until it is taken; no byte is lost or repeated.
// Reset (rst_ni low, asynchronous) returns the parser to the sync hunt,
// clears the sums and frame fields and empties the result register. The
// payload store is not cleared; its entries are undefined until written.
`include "gnss_binary_frame_parser_top_macros.svh"

module gnss_binary_frame_parser_top (
  input  logic clk_i,
  input  logic rst_ni,
  gbfp_in_if.sink    rx_i,
  gbfp_out_if.source res_o
);
  import gbfp_pkg::*;

  logic      step;
  result_t   result;
  store_wr_t store_wr;
  result_t   res_q;
  logic      res_valid_q;

  // A byte is taken whenever the result register is empty or being drained.
  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign step       = rx_i.valid && rx_i.ready;

  gbfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_byte_i  (rx_i.rx_byte),
    .result_o   (result),
    .store_wr_o (store_wr)
  );

  gbfp_store u_store (
    .clk_i (clk_i),
    .wr_i  ({store_wr.we && step, store_wr.addr, store_wr.data})
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      res_valid_q <= rx_i.valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.frame_status      = res_q.frame_status;
  assign res_o.frame_class       = res_q.frame_class;
  assign res_o.frame_ident       = res_q.frame_ident;
  assign res_o.frame_length      = res_q.frame_length;
  assign res_o.payload_truncated = res_q.payload_truncated;
  assign res_o.payload_valid     = res_q.payload_valid;
  assign res_o.payload_index     = res_q.payload_index;
  assign res_o.payload_data      = res_q.payload_data;

  // An empty result register never blocks the input.
  `GBFP_ASSERT(a_ready_when_empty, !res_valid_q |-> rx_i.ready, "input blocked while empty")
  // A store write shows up as the next result, at the same index.
  `GBFP_ASSERT(a_write_reported,
    (step && store_wr.we) |=> (res_valid_q && res_q.payload_valid &&
      res_q.payload_index == 9'($past(store_wr.addr))),
    "store write not reported")
  // A frame end never coincides with a stored payload byte.
  `GBFP_ASSERT(a_end_not_payload,
    (res_valid_q && res_q.frame_status != ST_NONE) |-> !res_q.payload_valid,
    "frame end on a payload byte")
  // The result register is found empty in the cycle after reset is seen.
  `GBFP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !res_valid_q, "result valid in reset")

endmodule

### hdl/gbfp_store.sv
module gbfp_store (
  input  logic                clk_i,
  input  gbfp_pkg::store_wr_t wr_i
);
  import gbfp_pkg::*;

  // Payload bytes of the current frame; contents undefined until written.
  logic [7:0] mem_q [MAX_PAYLOAD];

  // Single synchronous write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

endmodule

### hdl/gbfp_parser.sv
module gbfp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  output gbfp_pkg::result_t   result_o,
  output gbfp_pkg::store_wr_t store_wr_o
);
  import gbfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  ident_q, ident_d;
  logic [15:0] length_q, length_d;
  logic        over_q, over_d;

  logic [7:0]  fold_a;
  logic [7:0]  fold_b;
  logic        in_store;

  // Running Fletcher sums with the current byte folded in.
  assign fold_a   = sum_a_q + rx_byte_i;
  assign fold_b   = sum_b_q + fold_a;
  assign in_store = {1'b0, count_q} < 17'(MAX_PAYLOAD);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      count_q  <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      class_q  <= '0;
      ident_q  <= '0;
      length_q <= '0;
      over_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
      class_q  <= class_d;
      ident_q  <= ident_d;
      length_q <= length_d;
      over_q   <= over_d;
    end
  end

  // Next state and the result for the byte at the input.
  always_comb begin
    status_e status;
    status     = ST_NONE;
    phase_d    = phase_q;
    count_d    = count_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    class_d    = class_q;
    ident_d    = ident_q;
    length_d   = length_q;
    over_d     = over_q;
    store_wr_o = '0;

    case (phase_q)
      PH_HUNT1: begin
        if (rx_byte_i == SYNC_FIRST) phase_d = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (rx_byte_i == SYNC_SECOND) begin
          sum_a_d = '0;
          sum_b_d = '0;
          phase_d = PH_CLASS;
        end else if (rx_byte_i != SYNC_FIRST) begin
          phase_d = PH_HUNT1;
        end
      end
      PH_CLASS: begin
        class_d = rx_byte_i;
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        phase_d = PH_IDENT;
      end
      PH_IDENT: begin
        ident_d = rx_byte_i;
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        length_d = {8'h00, rx_byte_i};
        sum_a_d  = fold_a;
        sum_b_d  = fold_b;
        phase_d  = PH_LENHI;
      end
      PH_LENHI: begin
        length_d = {rx_byte_i, length_q[7:0]};
        sum_a_d  = fold_a;
        sum_b_d  = fold_b;
        count_d  = '0;
        over_d   = {1'b0, length_d} > 17'(MAX_PAYLOAD);
        phase_d  = (length_d == 16'h0000) ? PH_CKA : PH_BODY;
      end
      PH_BODY: begin
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        if (in_store) begin
          store_wr_o.we   = 1'b1;
          store_wr_o.addr = count_q[STORE_AW-1:0];
          store_wr_o.data = rx_byte_i;
        end
        // The count saturates so an endless body cannot wrap it.
        if (count_q != 16'hFFFF) count_d = count_q + 16'd1;
        if (count_d >= length_q) phase_d = PH_CKA;
      end
      PH_CKA: begin
        if (rx_byte_i != sum_a_q) begin
          phase_d = PH_HUNT1;
          status  = ST_BAD;
        end else begin
          phase_d = PH_CKB;
        end
      end
      PH_CKB: begin
        phase_d = PH_HUNT1;
        status  = (rx_byte_i == sum_b_q) ? ST_GOOD : ST_BAD;
      end
      default: begin
        phase_d = PH_HUNT1;
      end
    endcase

    result_o.frame_status      = status;
    result_o.frame_class       = class_d;
    result_o.frame_ident       = ident_d;
    result_o.frame_length      = length_d;
    result_o.payload_truncated = over_d;
    result_o.payload_valid     = store_wr_o.we;
    result_o.payload_index     = store_wr_o.we ? count_q[8:0] : 9'd0;
    result_o.payload_data      = store_wr_o.data;
  end

endmodule
